FILE: design/ht_pkg.sv
package ht_pkg;

    // event codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_UP    = 2'd1;
    localparam logic [1:0] KIND_DOWN  = 2'd2;
    localparam logic [1:0] KIND_POWER = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_BLINK_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_TICKS  = 2'd2;

    localparam logic [7:0]  SAMPLE_PERIOD_RESET = 8'd10;
    localparam logic [7:0]  BLINK_PERIOD_RESET  = 8'd99;
    localparam logic [15:0] WINDOW_TICKS_RESET  = 16'd1000;

    localparam logic [6:0] SETPOINT_RESET = 7'd60;
    localparam logic [6:0] SETPOINT_MAX   = 7'd75;
    localparam logic [6:0] SETPOINT_MIN   = 7'd35;
    localparam logic [6:0] SETPOINT_STEP  = 7'd5;
    localparam logic [9:0] HYSTERESIS     = 10'd5;
    localparam logic [7:0] BLINK_MAX      = 8'd255;

    localparam logic [18:0] FULL_SCALE_DEG = 19'd500;
    localparam logic [10:0] ADC_FULL       = 11'd1023;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] adc_sample;
    } item_t;

    typedef struct packed {
        logic [7:0]  sample_period;
        logic [7:0]  blink_period;
        logic [15:0] window_ticks;
    } cfg_t;

    typedef struct packed {
        logic       heater_on;
        logic       cooler_on;
        logic       status_led;
        logic       powered;
        logic [6:0] target_degrees;
        logic [8:0] measured_degrees;
        logic       adjusting;
    } res_t;

endpackage

FILE: design/ht_conv.sv
module ht_conv (
    input  logic [9:0] sample,
    output logic [8:0] degrees
);
    import ht_pkg::*;

    logic [18:0] prod;
    logic [8:0]  quot_est;
    logic [10:0] rem_est;

    // floor(sample*500/1023): estimate with >>10, remainder is below 2*1023
    always_comb begin
        prod     = 19'(sample) * FULL_SCALE_DEG;
        quot_est = prod[18:10];
        rem_est  = {1'b0, prod[9:0]} + {2'b00, quot_est};
        degrees  = (rem_est >= ADC_FULL) ? quot_est + 9'd1 : quot_est;
    end

endmodule

FILE: design/ht_ctrl.sv
module ht_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_en,
    input  ht_pkg::item_t item,
    input  ht_pkg::cfg_t  cfg,
    input  logic [8:0]    degrees,
    output ht_pkg::res_t  res
);
    import ht_pkg::*;

    logic [7:0]  sample_count_reg, sample_count_next;
    logic [7:0]  blink_count_reg, blink_count_next;
    logic [8:0]  temperature_reg, temperature_next;
    logic [6:0]  setpoint_reg, setpoint_next;
    logic        latch_reg, latch_next;
    logic        power_reg, power_next;
    logic        led_reg, led_next;
    logic [15:0] window_reg, window_next;

    logic [7:0] sc_inc;
    logic [8:0] setpoint_ext;
    logic       heater;
    logic       cooler;

    always_comb begin
        sample_count_next = sample_count_reg;
        blink_count_next  = blink_count_reg;
        temperature_next  = temperature_reg;
        setpoint_next     = setpoint_reg;
        latch_next        = latch_reg;
        power_next        = power_reg;
        led_next          = led_reg;
        window_next       = window_reg;
        heater            = 1'b0;
        cooler            = 1'b0;
        sc_inc            = sample_count_reg + 8'd1;

        // event update
        case (item.kind)
            KIND_TICK: begin
                sample_count_next = sc_inc;
                if (sc_inc == cfg.sample_period) begin
                    temperature_next  = degrees;
                    sample_count_next = '0;
                end
                if (blink_count_reg != BLINK_MAX) begin
                    blink_count_next = blink_count_reg + 8'd1;
                end
                if (window_reg != '0) begin
                    window_next = window_reg - 16'd1;
                end
            end
            KIND_UP, KIND_DOWN: begin
                if (window_reg != '0) begin
                    if (item.kind == KIND_UP && setpoint_reg < SETPOINT_MAX) begin
                        setpoint_next = setpoint_reg + SETPOINT_STEP;
                    end else if (item.kind == KIND_DOWN && setpoint_reg > SETPOINT_MIN) begin
                        setpoint_next = setpoint_reg - SETPOINT_STEP;
                    end
                end
                window_next = cfg.window_ticks;
            end
            KIND_POWER: begin
                power_next = ~power_reg;
            end
            default: begin
            end
        endcase

        // hysteresis control on the updated state
        setpoint_ext = {2'b00, setpoint_next};
        if (!power_next) begin
            led_next = 1'b0;
        end else if (temperature_next < setpoint_ext && !latch_reg) begin
            if (blink_count_next >= cfg.blink_period) begin
                led_next         = ~led_reg;
                blink_count_next = '0;
            end
            heater = 1'b1;
        end else if (temperature_next > setpoint_ext && !latch_reg) begin
            led_next = 1'b1;
            cooler   = 1'b1;
        end else begin
            led_next   = 1'b0;
            latch_next = !(({1'b0, temperature_next} + HYSTERESIS) <= {1'b0, setpoint_ext}
                           || temperature_next > setpoint_ext);
        end

        res.heater_on        = heater;
        res.cooler_on        = cooler;
        res.status_led       = led_next;
        res.powered          = power_next;
        res.target_degrees   = setpoint_next;
        res.measured_degrees = temperature_next;
        res.adjusting        = (window_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= '0;
            blink_count_reg  <= '0;
            temperature_reg  <= '0;
            setpoint_reg     <= SETPOINT_RESET;
            latch_reg        <= 1'b0;
            power_reg        <= 1'b1;
            led_reg          <= 1'b0;
            window_reg       <= '0;
        end else if (item_en) begin
            sample_count_reg <= sample_count_next;
            blink_count_reg  <= blink_count_next;
            temperature_reg  <= temperature_next;
            setpoint_reg     <= setpoint_next;
            latch_reg        <= latch_next;
            power_reg        <= power_next;
            led_reg          <= led_next;
            window_reg       <= window_next;
        end
    end

endmodule

FILE: design/heater_thermostat_with_hysteresis_unit.sv
// flow: an accepted input transaction waits in the input register, then passes the control
//   logic into the result register once that register is free or draining
// throughput: one transaction per cycle unless the receiver stalls the result channel
// reset: aresetn is synchronous and active low; it empties both stages and loads
//   the power-on state (setpoint 60, powered, window closed) and default registers
module heater_thermostat_with_hysteresis_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [9:0]  s_adc_sample,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_heater_on,
    output logic        m_cooler_on,
    output logic        m_status_led,
    output logic        m_powered,
    output logic [6:0]  m_target_degrees,
    output logic [8:0]  m_measured_degrees,
    output logic        m_adjusting
);
    import ht_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  in_vld_reg;
    logic  out_vld_reg;
    res_t  res_reg;

    res_t       res;
    logic [8:0] degrees;
    logic       accept;
    logic       advance;

    // the held transaction moves on whenever the result register is free or draining
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign accept  = s_valid && s_ready;

    // configuration registers, to be written only while idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period <= SAMPLE_PERIOD_RESET;
            cfg_reg.blink_period  <= BLINK_PERIOD_RESET;
            cfg_reg.window_ticks  <= WINDOW_TICKS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg_wdata[7:0];
                CFG_BLINK_PERIOD:  cfg_reg.blink_period  <= cfg_wdata[7:0];
                CFG_WINDOW_TICKS:  cfg_reg.window_ticks  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (accept) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.kind       <= s_kind;
            item_reg.adc_sample <= s_adc_sample;
        end
    end

    // adc counts to whole degrees
    ht_conv u_conv (
        .sample  (item_reg.adc_sample),
        .degrees (degrees)
    );

    // event handling, hysteresis state and drive decisions
    ht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .degrees (degrees),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_heater_on        = res_reg.heater_on;
    assign m_cooler_on        = res_reg.cooler_on;
    assign m_status_led       = res_reg.status_led;
    assign m_powered          = res_reg.powered;
    assign m_target_degrees   = res_reg.target_degrees;
    assign m_measured_degrees = res_reg.measured_degrees;
    assign m_adjusting        = res_reg.adjusting;

`ifndef SYNTHESIS
    // heater and cooler are exclusive
    a_drive_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> !(res_reg.heater_on && res_reg.cooler_on))
        else $error("heater and cooler driven together");

    // power off forces every drive low
    a_power_off_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !res_reg.powered) |->
            (!res_reg.heater_on && !res_reg.cooler_on && !res_reg.status_led))
        else $error("drive active while powered off");

    // heating only below setpoint, cooling only above it
    a_heat_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && res_reg.heater_on) |->
            (res_reg.measured_degrees < {2'b00, res_reg.target_degrees}))
        else $error("heater on at or above setpoint");

    a_cool_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && res_reg.cooler_on) |->
            (res_reg.measured_degrees > {2'b00, res_reg.target_degrees}))
        else $error("cooler on at or below setpoint");

    // an accepted transaction always lands in the input register
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> in_vld_reg)
        else $error("accepted transaction lost");
`endif

endmodule

FILE: test/heater_thermostat_with_hysteresis_unit_tb.sv
`timescale 1ns / 100ps

module heater_thermostat_with_hysteresis_unit_tb;

    import ht_pkg::*;

    // run control
    localparam int CYCLE_LIMIT     = 200000;  // generous watchdog
    localparam int DRAIN_CYCLES    = 8;       // settle time after the last result
    localparam int MAX_REPORTS     = 50;      // keep the log short on a broken build
    localparam int STALL_CYCLES    = 150;     // long receiver hold-off for the fill-up test
    localparam int BASE_GAP_PCT    = 28;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_SAMPLE_PERIOD;
    logic [15:0] cfg_wdata = '0;

    // event channel
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind       = KIND_TICK;
    logic [9:0]  s_adc_sample = '0;

    // result channel
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_heater_on;
    logic        m_cooler_on;
    logic        m_status_led;
    logic        m_powered;
    logic [6:0]  m_target_degrees;
    logic [8:0]  m_measured_degrees;
    logic        m_adjusting;

    heater_thermostat_with_hysteresis_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_adc_sample       (s_adc_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_heater_on        (m_heater_on),
        .m_cooler_on        (m_cooler_on),
        .m_status_led       (m_status_led),
        .m_powered          (m_powered),
        .m_target_degrees   (m_target_degrees),
        .m_measured_degrees (m_measured_degrees),
        .m_adjusting        (m_adjusting)
    );

    // 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // thermostat predictor: own copy of registers and state
    // ---------------------------------------------------------------
    logic [7:0]  th_sample_period;
    logic [7:0]  th_blink_period;
    logic [15:0] th_window_ticks;

    logic [7:0]  th_sample_cnt;
    logic [7:0]  th_blink_cnt;
    logic [8:0]  th_temperature;
    logic [6:0]  th_setpoint;
    logic        th_reached;
    logic        th_power;
    logic        th_led;
    logic [15:0] th_window_cnt;

    // outputs the thermostat should show, oldest transaction first
    res_t thermostat_expected_q[$];

    // shared controls between the stimulus and the receiver
    int gap_pct     = BASE_GAP_PCT;
    int hold_cycles = 0;

    // bookkeeping
    int cycle_count  = 0;
    int n_ticks      = 0;
    int n_presses    = 0;
    int n_toggles    = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_reg_writes = 0;

    task automatic reset_thermostat_state();
        th_sample_period = SAMPLE_PERIOD_RESET;
        th_blink_period  = BLINK_PERIOD_RESET;
        th_window_ticks  = WINDOW_TICKS_RESET;
        th_sample_cnt    = '0;
        th_blink_cnt     = '0;
        th_temperature   = '0;
        th_setpoint      = SETPOINT_RESET;
        th_reached       = 1'b0;
        th_power         = 1'b1;
        th_led           = 1'b0;
        th_window_cnt    = '0;
    endtask

    // advance the predicted state by one event and return the outputs it shows
    task automatic predict_thermostat(input logic [1:0] kind, input logic [9:0] sample,
                                      output res_t outs);
        int temp_deg;
        int set_deg;
        int conv;
        logic heat;
        logic cool;
        heat = 1'b0;
        cool = 1'b0;

        case (kind)
            KIND_TICK: begin
                th_sample_cnt = th_sample_cnt + 8'd1;   // wraps at 256
                if (th_sample_cnt == th_sample_period) begin
                    conv           = int'(sample) * int'(FULL_SCALE_DEG) / int'(ADC_FULL);
                    th_temperature = conv[8:0];
                    th_sample_cnt  = '0;
                end
                if (th_blink_cnt != BLINK_MAX)
                    th_blink_cnt = th_blink_cnt + 8'd1;
                if (th_window_cnt != 16'd0)
                    th_window_cnt = th_window_cnt - 16'd1;
            end
            KIND_UP, KIND_DOWN: begin
                // only a press inside an open window moves the setpoint
                if (th_window_cnt != 16'd0) begin
                    if (kind == KIND_UP && th_setpoint < SETPOINT_MAX)
                        th_setpoint = th_setpoint + SETPOINT_STEP;
                    else if (kind == KIND_DOWN && th_setpoint > SETPOINT_MIN)
                        th_setpoint = th_setpoint - SETPOINT_STEP;
                end
                th_window_cnt = th_window_ticks;
            end
            default: begin
                th_power = ~th_power;
            end
        endcase

        temp_deg = int'(th_temperature);
        set_deg  = int'(th_setpoint);
        if (!th_power) begin
            th_led = 1'b0;
        end else if (temp_deg < set_deg && !th_reached) begin
            if (th_blink_cnt >= th_blink_period) begin
                th_led       = ~th_led;
                th_blink_cnt = '0;
            end
            heat = 1'b1;
        end else if (temp_deg > set_deg && !th_reached) begin
            th_led = 1'b1;
            cool   = 1'b1;
        end else begin
            // at setpoint or latched: all off, latch drops outside the band
            th_reached = 1'b1;
            th_led     = 1'b0;
            if (temp_deg + int'(HYSTERESIS) <= set_deg || temp_deg > set_deg)
                th_reached = 1'b0;
        end

        outs.heater_on        = heat;
        outs.cooler_on        = cool;
        outs.status_led       = th_led;
        outs.powered          = th_power;
        outs.target_degrees   = th_setpoint;
        outs.measured_degrees = th_temperature;
        outs.adjusting        = (th_window_cnt != 16'd0);
    endtask

    // one line of result fields for the mismatch report
    function automatic string format_res(input res_t r);
        return $sformatf("heat=%b cool=%b led=%b pwr=%b set=%0d meas=%0d adj=%b",
                         r.heater_on, r.cooler_on, r.status_led, r.powered,
                         r.target_degrees, r.measured_degrees, r.adjusting);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // offer one event; valid stays up from one transaction to the next unless a gap is drawn
    task automatic send_event(input logic [1:0] kind, input logic [9:0] sample);
        res_t outs;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_adc_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge
        predict_thermostat(kind, sample, outs);
        thermostat_expected_q.push_back(outs);
        case (kind)
            KIND_TICK:          n_ticks++;
            KIND_UP, KIND_DOWN: n_presses++;
            default:            n_toggles++;
        endcase
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (thermostat_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    // single-cycle register write, only issued while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SAMPLE_PERIOD: th_sample_period = data[7:0];
            CFG_BLINK_PERIOD:  th_blink_period  = data[7:0];
            CFG_WINDOW_TICKS:  th_window_ticks  = data;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // mostly ticks around the setpoint range, bursts of presses, short power-off spells
    task automatic run_random_events(input int count);
        int pick;
        int toggle_pct;
        for (int i = 0; i < count; i++) begin
            pick       = $urandom_range(0, 99);
            toggle_pct = th_power ? 2 : 15;
            if (pick < toggle_pct)
                send_event(KIND_POWER, 10'($urandom));
            else if (pick < toggle_pct + 11)
                send_event(KIND_UP, 10'($urandom));
            else if (pick < toggle_pct + 22)
                send_event(KIND_DOWN, 10'($urandom));
            else if (pick < toggle_pct + 35)
                send_event(KIND_TICK, 10'($urandom));
            else
                send_event(KIND_TICK, 10'($urandom_range(40, 180)));  // about 19..88 degrees
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // power-on values: setpoint 60, powered, window closed, default periods
    task automatic test_reset_state();
        send_event(KIND_TICK, 10'h3FF);
        send_event(KIND_TICK, 10'h000);
        drain_results();
    endtask

    // field extremes, every event kind, setpoint limits, power off
    task automatic test_directed_events();
        write_reg(CFG_SAMPLE_PERIOD, 16'd1);
        write_reg(CFG_BLINK_PERIOD, 16'd0);    // zero blink period: toggle every heating step
        write_reg(CFG_WINDOW_TICKS, 16'd3);
        send_event(KIND_TICK, 10'h3FF);        // full scale, not sampled yet: heating
        send_event(KIND_TICK, 10'h000);        // zero, heating with blink
        send_event(KIND_TICK, 10'h000);
        send_event(KIND_DOWN, 10'h000);        // window closed: opens it, no move
        send_event(KIND_DOWN, 10'h3FF);        // now moves to 55
        repeat (5) send_event(KIND_UP, 10'h155);    // up to 75 and stuck at the top
        repeat (9) send_event(KIND_DOWN, 10'h2AA);  // down to 35 and stuck at the bottom
        send_event(KIND_TICK, 10'd72);         // no sample taken: still heating, latch stays clear
        send_event(KIND_TICK, 10'd66);         // still heating, latch stays clear
        send_event(KIND_TICK, 10'd61);         // still heating
        send_event(KIND_TICK, 10'd61);         // still heating
        send_event(KIND_POWER, 10'h000);       // switched off
        send_event(KIND_TICK, 10'h3FF);        // outputs forced off
        send_event(KIND_POWER, 10'h3FF);       // back on, heating
        drain_results();
    endtask

    // zero window and zero sample period, plus blink count saturation
    task automatic test_zero_settings();
        write_reg(CFG_WINDOW_TICKS, 16'd0);    // presses never open the window
        send_event(KIND_UP, 10'h000);
        send_event(KIND_DOWN, 10'h000);
        send_event(KIND_UP, 10'h000);
        send_event(KIND_TICK, 10'h000);        // sample period still 1: cold reading
        drain_results();
        write_reg(CFG_SAMPLE_PERIOD, 16'd0);   // a sample every 256 ticks
        write_reg(CFG_BLINK_PERIOD, 16'hFF00 | 16'd255);  // upper bits are ignored
        repeat (262) send_event(KIND_TICK, 10'($urandom));
        drain_results();
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        gap_pct     = 0;
        hold_cycles = STALL_CYCLES;
        for (int i = 0; i < 60; i++)
            send_event(KIND_TICK, 10'($urandom));
        drain_results();
        gap_pct = BASE_GAP_PCT;
    endtask

    // one random phase under a given register setting
    task automatic test_random_settings(input logic [7:0] sample_period,
                                        input logic [7:0] blink_period,
                                        input logic [15:0] window_ticks,
                                        input int count, input bit no_gaps);
        write_reg(CFG_SAMPLE_PERIOD, {8'($urandom), sample_period});
        write_reg(CFG_BLINK_PERIOD, {8'($urandom), blink_period});
        write_reg(CFG_WINDOW_TICKS, window_ticks);
        gap_pct = no_gaps ? 0 : BASE_GAP_PCT;
        run_random_events(count);
        drain_results();
        gap_pct = BASE_GAP_PCT;
    endtask

    // ---------------------------------------------------------------
    // result checker and receiver ready
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (m_valid && m_ready) begin
            got = '{m_heater_on, m_cooler_on, m_status_led, m_powered,
                    m_target_degrees, m_measured_degrees, m_adjusting};
            if (thermostat_expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = thermostat_expected_q.pop_front();
                n_checked++;
                if (got.heater_on !== want.heater_on ||
                    got.cooler_on !== want.cooler_on ||
                    got.status_led !== want.status_led ||
                    got.powered !== want.powered ||
                    got.target_degrees !== want.target_degrees ||
                    got.measured_degrees !== want.measured_degrees ||
                    got.adjusting !== want.adjusting) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: mismatch expected %s got %s",
                                 $time, format_res(want), format_res(got));
                end
            end
        end
        // long hold-off when asked, random ready otherwise
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= gap_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, thermostat_expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        reset_thermostat_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed_events();
        test_zero_settings();
        test_random_settings(SAMPLE_PERIOD_RESET, BLINK_PERIOD_RESET, WINDOW_TICKS_RESET,
                             250, 1'b0);
        test_random_settings(8'd1, 8'd1, 16'd1, 300, 1'b1);        // low extremes, no gaps
        test_random_settings(8'd255, 8'd255, 16'hFFFF, 150, 1'b0); // high extremes
        test_output_backpressure();
        test_random_settings(8'($urandom_range(1, 4)), 8'($urandom_range(0, 20)),
                             16'($urandom_range(1, 40)), 250, 1'b0);
        test_random_settings(8'($urandom_range(1, 8)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(1, 65535)), 250, 1'b0);

        // let anything still in flight show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d events (%0d ticks, %0d presses, %0d toggles), %0d checked",
                 n_ticks + n_presses + n_toggles, n_ticks, n_presses, n_toggles, n_checked);
        $display("%0d register writes incl. zero and full-scale values, one long output stall",
                 n_reg_writes);
        if (n_errors == 0 && thermostat_expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results never arrived", n_errors,
                     thermostat_expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
